### hdl/assert_macros.svh
// Assertion macros used by the checker of the irrigation controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define SMIC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is checked at every edge, reset included.
`define SMIC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/smic_pkg.sv
// Types, constants and helper functions of the soil moisture irrigation controller.
`timescale 1ns / 1ps

package smic_pkg;

   localparam int CHANNELS_DEFAULT = 4;

   localparam int CMD_W      = 2;
   localparam int CHAN_W     = 2;
   localparam int SAMPLE_W   = 10;
   localparam int HUM_W      = 7;
   localparam int CNT_W      = 17;
   localparam int TICK_W     = 16;
   localparam int THRESH_W   = 28;
   localparam int MASK_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   // Command codes of a request.
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLDS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_MASK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANALOG_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANALOG_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_TICKS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_INTV = 3'd6;

   // Configuration reset values.
   localparam logic [SAMPLE_W-1:0] ANALOG_MAX_RESET  = 10'd1023;
   localparam logic [TICK_W-1:0]   PAUSE_TICKS_RESET = 16'd60;
   localparam logic [TICK_W-1:0]   RUN_TICKS_RESET   = 16'd30;
   localparam logic [TICK_W-1:0]   REPORT_INTV_RESET = 16'd10;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Division of a 10-bit magnitude by ten: multiply by 205, drop 11 bits.
   localparam logic [7:0] RECIP_TEN   = 8'd205;
   localparam int         RECIP_SHIFT = 11;
   localparam int         RECIP_PROD_W = SAMPLE_W + 8;

   localparam logic [HUM_W-1:0] PCT_FULL = 7'd100;

   // Percent scaling divider operand widths.
   localparam int QUOT_W = 17;
   localparam int DEN_W  = 10;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_IRRIGATE,
      PH_STOP
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT,
      ST_SCALE,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      phase_type             phase;
      logic [CNT_W-1:0]      run_cnt;
      logic [CNT_W-1:0]      rep_cnt;
      logic [SAMPLE_W-1:0]   filt;
      logic [HUM_W-1:0]      hum;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{
      phase:   PH_IDLE,
      run_cnt: 17'd60,
      rep_cnt: 17'd10,
      filt:    '0,
      hum:     '0
   };

   typedef struct packed {
      logic              start;
      logic [QUOT_W-1:0] num;
      logic [DEN_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] x);
      return (x == CNT_MAX) ? x : x + 1'b1;
   endfunction

endpackage

### hdl/smic_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module smic_ram #(
   parameter int WIDTH = smic_pkg::ENTRY_W,
   parameter int DEPTH = smic_pkg::CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/smic_div.sv
// Restoring divider, one quotient bit per cycle, for the humidity percent scaling.
`timescale 1ns / 1ps

module smic_div (
   input  logic                     clock,
   input  logic                     reset,
   input  smic_pkg::div_req_type    div_req,
   output smic_pkg::div_rsp_type    div_rsp
);

   localparam int NW     = smic_pkg::QUOT_W;
   localparam int DW     = smic_pkg::DEN_W;
   localparam int STEP_W = $clog2(NW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     den_ff, den_in;

   logic [DW:0]       trial;
   logic [DW:0]       trial_sub;
   logic              ge;

   assign trial     = {rem_ff, quo_ff[NW-1]};
   assign ge        = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(NW);
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor when the divisor is nonzero.
         rem_in = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

### hdl/soil_moisture_irrigation_controller.sv
// Top level of the per-channel soil moisture irrigation controller.
//
//   channel | ports                                   | accepted when
//   --------+-----------------------------------------+--------------------------
//   request | req_cmd, req_channel, req_analog_sample | req_valid && req_ready
//   result  | rsp_out_channel .. rsp_humidity_event   | rsp_valid && rsp_ready
//   config  | csr_index, csr_wdata                    | csr_we
//
// One request is processed at a time. A manual command or a tick without a
// sample skips the scale step and the 17-step percent divider that a sampling
// tick passes. Channel state lives in a RAM with a registered read; a valid
// bit per channel stands in for its reset contents. Reset is synchronous and
// active high. A result waiting in the output register does not block the
// next request until that request reaches its write-back step.
`timescale 1ns / 1ps

module soil_moisture_irrigation_controller #(
   parameter int CHANNELS = smic_pkg::CHANNELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [smic_pkg::CMD_W-1:0]         req_cmd,
   input  logic [smic_pkg::CHAN_W-1:0]        req_channel,
   input  logic [smic_pkg::SAMPLE_W-1:0]      req_analog_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [smic_pkg::CHAN_W-1:0]        rsp_out_channel,
   output logic                               rsp_motor_on,
   output logic                               rsp_motor_event,
   output logic [smic_pkg::HUM_W-1:0]         rsp_humidity,
   output logic                               rsp_humidity_event,
   input  logic                               csr_we,
   input  logic [smic_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smic_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W  = smic_pkg::CNT_W;
   localparam int SW     = smic_pkg::SAMPLE_W;
   localparam int HW     = smic_pkg::HUM_W;
   localparam int PW     = smic_pkg::RECIP_PROD_W;
   localparam int NUM_W  = smic_pkg::QUOT_W + 1;

   // Configuration registers.
   logic [smic_pkg::THRESH_W-1:0] thresh_ff;
   logic [smic_pkg::MASK_W-1:0]   auto_ff;
   logic [SW-1:0]                 min_ff;
   logic [SW-1:0]                 max_ff;
   logic [smic_pkg::TICK_W-1:0]   pause_ff;
   logic [smic_pkg::TICK_W-1:0]   run_ff;
   logic [smic_pkg::TICK_W-1:0]   intv_ff;

   // Request held for the duration of its processing.
   logic [smic_pkg::CMD_W-1:0]    cmd_ff;
   logic [smic_pkg::CHAN_W-1:0]   chan_ff;
   logic [SW-1:0]                 sample_ff;

   smic_pkg::state_type           state_ff, state_in;
   logic [CHANNELS-1:0]           valid_ff;
   smic_pkg::entry_type           upd_ff, upd_in;
   logic                          hum_ev_ff, hum_ev_in;
   logic                          zero_ff, zero_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [smic_pkg::CHAN_W-1:0]   rsp_chan_ff, rsp_chan_in;
   logic                          rsp_on_ff, rsp_on_in;
   logic                          rsp_mev_ff, rsp_mev_in;
   logic [HW-1:0]                 rsp_hum_ff, rsp_hum_in;
   logic                          rsp_hev_ff, rsp_hev_in;

   logic                          accept;
   logic                          in_range;
   logic                          out_free;
   logic [AW-1:0]                 idx;
   logic                          ram_we;
   logic [smic_pkg::ENTRY_W-1:0]  ram_rdata;
   smic_pkg::entry_type           cur;

   logic                          do_samp;
   logic signed [SW:0]            fdiff;
   logic [SW-1:0]                 fmag;
   logic [PW-1:0]                 fprod;
   logic [SW-1:0]                 fstep;
   logic [SW-1:0]                 filt_new;

   logic signed [SW:0]            sdiff;
   logic signed [NUM_W-1:0]       snum;
   logic signed [SW:0]            sden;
   logic [smic_pkg::QUOT_W-1:0]   num_mag;
   logic [smic_pkg::DEN_W-1:0]    den_mag;
   logic                          zero_c;
   logic [HW-1:0]                 hum_div;

   smic_pkg::div_req_type         div_req;
   smic_pkg::div_rsp_type         div_rsp;

   smic_pkg::entry_type           mach_entry;
   logic                          mach_on;
   logic                          mach_ev;
   logic [HW-1:0]                 thresh;
   logic [CNT_W-1:0]              pause_ext;
   logic [CNT_W-1:0]              run_ext;

   assign accept   = req_valid && req_ready;
   assign in_range = ({1'b0, chan_ff} < 3'(CHANNELS));
   assign idx      = chan_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   smic_ram #(
      .WIDTH (smic_pkg::ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx),
      .wdata (mach_entry),
      .re    (accept),
      .raddr (req_channel[AW-1:0]),
      .rdata (ram_rdata)
   );

   smic_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A channel that was never written back reads as its reset contents.
   assign cur = valid_ff[idx] ? smic_pkg::entry_type'(ram_rdata) : smic_pkg::ENTRY_RESET;

   // Low-pass step: filt += (sample - filt) / 10, truncated toward zero.
   assign do_samp  = (cur.rep_cnt > CNT_W'(intv_ff));
   assign fdiff    = $signed({1'b0, sample_ff}) - $signed({1'b0, cur.filt});
   assign fmag     = fdiff[SW] ? SW'(-fdiff) : SW'(fdiff);
   assign fprod    = PW'(fmag) * PW'(smic_pkg::RECIP_TEN);
   assign fstep    = SW'(fprod[PW-1:smic_pkg::RECIP_SHIFT]);
   assign filt_new = fdiff[SW] ? (cur.filt - fstep) : (cur.filt + fstep);

   // Percent scaling operands; the quotient is used by magnitude only.
   assign sdiff   = $signed({1'b0, upd_ff.filt}) - $signed({1'b0, min_ff});
   assign snum    = NUM_W'(sdiff) * $signed(NUM_W'(smic_pkg::PCT_FULL));
   assign sden    = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
   assign num_mag = snum[NUM_W-1] ? smic_pkg::QUOT_W'(-snum) : smic_pkg::QUOT_W'(snum);
   assign den_mag = sden[SW] ? smic_pkg::DEN_W'(-sden) : smic_pkg::DEN_W'(sden);
   // Equal endpoints or a negative quotient both end at zero percent.
   assign zero_c  = (sden == '0) || (snum[NUM_W-1] ^ sden[SW]);
   assign hum_div = zero_ff ? '0 :
                    (div_rsp.quot > smic_pkg::QUOT_W'(smic_pkg::PCT_FULL)) ?
                    smic_pkg::PCT_FULL : div_rsp.quot[HW-1:0];

   assign thresh    = thresh_ff[HW*chan_ff +: HW];
   assign pause_ext = CNT_W'(pause_ff);
   assign run_ext   = CNT_W'(run_ff);

   // Phase machine of the addressed channel, applied at write-back.
   always_comb begin
      mach_entry = upd_ff;
      mach_on    = 1'b0;
      mach_ev    = 1'b0;
      case (cmd_ff)
         smic_pkg::CMD_START: begin
            mach_entry.phase = smic_pkg::PH_START;
         end
         smic_pkg::CMD_STOP: begin
            mach_entry.phase = smic_pkg::PH_STOP;
         end
         smic_pkg::CMD_TICK: begin
            case (upd_ff.phase)
               smic_pkg::PH_IDLE: begin
                  if (upd_ff.run_cnt <= pause_ext) begin
                     mach_entry.run_cnt = smic_pkg::inc_sat(upd_ff.run_cnt);
                  end
                  if ((mach_entry.run_cnt >= pause_ext) && auto_ff[chan_ff] &&
                      (upd_ff.hum < thresh)) begin
                     mach_entry.phase = smic_pkg::PH_START;
                  end
               end
               smic_pkg::PH_START: begin
                  mach_entry.run_cnt = '0;
                  mach_entry.phase   = smic_pkg::PH_IRRIGATE;
                  mach_on            = 1'b1;
                  mach_ev            = 1'b1;
               end
               smic_pkg::PH_IRRIGATE: begin
                  if (upd_ff.run_cnt > run_ext) begin
                     mach_entry.phase = smic_pkg::PH_STOP;
                  end
                  mach_entry.run_cnt = smic_pkg::inc_sat(upd_ff.run_cnt);
               end
               default: begin
                  mach_entry.run_cnt = '0;
                  mach_entry.phase   = smic_pkg::PH_IDLE;
                  mach_ev            = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in      = state_ff;
      upd_in        = upd_ff;
      hum_ev_in     = hum_ev_ff;
      zero_in       = zero_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = num_mag;
      div_req.den   = den_mag;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_chan_in   = rsp_chan_ff;
      rsp_on_in     = rsp_on_ff;
      rsp_mev_in    = rsp_mev_ff;
      rsp_hum_in    = rsp_hum_ff;
      rsp_hev_in    = rsp_hev_ff;
      case (state_ff)
         smic_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = smic_pkg::ST_FILT;
            end
         end
         smic_pkg::ST_FILT: begin
            upd_in    = cur;
            hum_ev_in = 1'b0;
            state_in  = smic_pkg::ST_WRITE;
            if (cmd_ff == smic_pkg::CMD_TICK) begin
               upd_in.rep_cnt = smic_pkg::inc_sat(cur.rep_cnt);
               if (do_samp) begin
                  upd_in.rep_cnt = '0;
                  upd_in.filt    = filt_new;
                  state_in       = smic_pkg::ST_SCALE;
               end
            end
         end
         smic_pkg::ST_SCALE: begin
            zero_in       = zero_c;
            div_req.start = 1'b1;
            state_in      = smic_pkg::ST_DIV;
         end
         smic_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               hum_ev_in  = (hum_div != upd_ff.hum);
               upd_in.hum = hum_div;
               state_in   = smic_pkg::ST_WRITE;
            end
         end
         smic_pkg::ST_WRITE: begin
            if (out_free) begin
               ram_we       = in_range;
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_ff;
               rsp_on_in    = in_range && mach_on;
               rsp_mev_in   = in_range && mach_ev;
               rsp_hum_in   = in_range ? upd_ff.hum : '0;
               rsp_hev_in   = in_range && hum_ev_ff;
               state_in     = smic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smic_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smic_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         auto_ff   <= '0;
         min_ff    <= '0;
         max_ff    <= smic_pkg::ANALOG_MAX_RESET;
         pause_ff  <= smic_pkg::PAUSE_TICKS_RESET;
         run_ff    <= smic_pkg::RUN_TICKS_RESET;
         intv_ff   <= smic_pkg::REPORT_INTV_RESET;
      end else if (csr_we) begin
         case (csr_index)
            smic_pkg::CSR_THRESHOLDS:  thresh_ff <= csr_wdata;
            smic_pkg::CSR_AUTO_MASK:   auto_ff   <= csr_wdata[smic_pkg::MASK_W-1:0];
            smic_pkg::CSR_ANALOG_MIN:  min_ff    <= csr_wdata[SW-1:0];
            smic_pkg::CSR_ANALOG_MAX:  max_ff    <= csr_wdata[SW-1:0];
            smic_pkg::CSR_PAUSE_TICKS: pause_ff  <= csr_wdata[smic_pkg::TICK_W-1:0];
            smic_pkg::CSR_RUN_TICKS:   run_ff    <= csr_wdata[smic_pkg::TICK_W-1:0];
            smic_pkg::CSR_REPORT_INTV: intv_ff   <= csr_wdata[smic_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         chan_ff   <= req_channel;
         sample_ff <= req_analog_sample;
      end
      upd_ff      <= upd_in;
      hum_ev_ff   <= hum_ev_in;
      zero_ff     <= zero_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_mev_ff  <= rsp_mev_in;
      rsp_hum_ff  <= rsp_hum_in;
      rsp_hev_ff  <= rsp_hev_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_chan_ff;
   assign rsp_motor_on       = rsp_on_ff;
   assign rsp_motor_event    = rsp_mev_ff;
   assign rsp_humidity       = rsp_hum_ff;
   assign rsp_humidity_event = rsp_hev_ff;

endmodule

### hdl/smic_checker.sv
// Port-level checker of the irrigation controller and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smic_checker #(
   parameter int CHANNELS = smic_pkg::CHANNELS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic [smic_pkg::CHAN_W-1:0]        rsp_out_channel,
   input logic                               rsp_motor_on,
   input logic                               rsp_motor_event,
   input logic [smic_pkg::HUM_W-1:0]         rsp_humidity,
   input logic                               rsp_humidity_event
);

   localparam logic [2:0] CHAN_LIMIT = 3'(CHANNELS);

   logic on_shown;
   logic hum_ok;
   logic rsp_absent;
   logic rsp_quiet;
   logic req_taken;

   assign on_shown   = rsp_valid && rsp_motor_on;
   assign hum_ok     = (rsp_humidity <= smic_pkg::PCT_FULL);
   assign rsp_absent = rsp_valid && ({1'b0, rsp_out_channel} >= CHAN_LIMIT);
   assign rsp_quiet  = (rsp_humidity == '0) && !rsp_motor_event && !rsp_humidity_event;
   assign req_taken  = req_valid && req_ready;

   // A pump-on level is only ever shown together with a pump command.
   `SMIC_ASSERT(a_motor_on_event, clock, reset, on_shown |-> rsp_motor_event, "motor on, no event")

   `SMIC_ASSERT(a_humidity_range, clock, reset, rsp_valid |-> hum_ok, "humidity above 100")

   // A channel the block does not have reports nothing.
   `SMIC_ASSERT(a_absent_channel, clock, reset, rsp_absent |-> rsp_quiet, "absent channel data")

   // Requests are processed one at a time.
   `SMIC_ASSERT(a_one_at_a_time, clock, reset, req_taken |=> !req_ready, "second request taken")

   `SMIC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result after reset")

endmodule

bind soil_moisture_irrigation_controller smic_checker #(.CHANNELS(CHANNELS)) u_smic_checker (.*);
